// File: src/mpe_pkg.sv
package mpe_pkg;

  localparam int unsigned NumCh = 15;
  localparam logic [3:0] NoCh = 4'd0;

  typedef enum logic [1:0] {
    OpNoteOn  = 2'd0,
    OpNoteOff = 2'd1,
    OpExpr    = 2'd2,
    OpAllOff  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    MkNoteOn  = 3'd0,
    MkNoteOff = 3'd1,
    MkBend    = 3'd2,
    MkCc      = 3'd3,
    MkChPress = 3'd4,
    MkPoly    = 3'd5,
    MkAllOff  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    RegMpe    = 3'd0,
    RegZone   = 3'd1,
    RegLowest = 3'd2,
    RegHigh   = 3'd3,
    RegBase   = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [6:0]         note_code;
    logic [6:0]         velocity;
    logic [3:0]         input_channel;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic [1:0]         expr_dimension;
    logic signed [31:0] expr_value;
    logic [3:0]         member_channel;
  } in_t;

  typedef struct packed {
    logic [2:0] msg_kind;
    logic [3:0] out_channel;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic       last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic pop;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic has_msg;
  } sts_t;

endpackage

// File: src/mpe_ctrl.sv
module mpe_ctrl import mpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWork = 3'b010,
    StOut  = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign cmd_o.start = in_valid_i && (state_q == StIdle);
  assign cmd_o.pop   = out_ready_i && (state_q == StOut);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StWork;
      StWork: begin
        if (sts_i.has_msg) state_d = StOut;
        else if (!sts_i.busy) state_d = StIdle;
      end
      StOut: if (out_ready_i) state_d = StWork;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

endmodule

// File: src/mpe_dp.sv
module mpe_dp import mpe_pkg::*; #(
  parameter int unsigned MaxNotes = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  in_t        in_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output out_t       out_o
);

  localparam int unsigned IW = (MaxNotes > 1) ? $clog2(MaxNotes) : 1;
  localparam int unsigned CW = $clog2(MaxNotes + 1);

  typedef enum logic [12:0] {
    PIdle   = 13'h0001,
    PFind   = 13'h0002,
    PCount  = 13'h0004,
    PChoose = 13'h0008,
    PAvgLd  = 13'h0010,
    PDiv    = 13'h0020,
    PEmit   = 13'h0040,
    POffAvg = 13'h0080,
    PExSum  = 13'h0100,
    PExDiv  = 13'h0200,
    PExSend = 13'h0400,
    PAllOff = 13'h0800,
    PDone   = 13'h1000
  } ph_e;

  // config
  logic mpe_q, zone_q;
  logic [3:0] lowm_q, highm_q, base_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpe_q <= 1'b0; zone_q <= 1'b0; lowm_q <= 4'd1; highm_q <= 4'd14; base_q <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMpe:    mpe_q <= cfg_data_i[0];
        RegZone:   zone_q <= cfg_data_i[0];
        RegLowest: lowm_q <= cfg_data_i;
        RegHigh:   highm_q <= cfg_data_i;
        RegBase:   base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [3:0] clampm(logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v == 4'd15) return 4'd14;
    return v;
  endfunction

  logic [3:0] lm, hm, lo_c, hi_c;
  assign lm = clampm(lowm_q);
  assign hm = clampm(highm_q);
  assign lo_c = zone_q ? lm : 4'd1;
  assign hi_c = zone_q ? 4'd14 : hm;

  // note table, mc of 0 = unassigned (channel 0 is never a member)
  logic [MaxNotes-1:0] nv_q;
  logic [6:0]  nn_q [MaxNotes];
  logic [3:0]  ni_q [MaxNotes];
  logic [3:0]  nm_q [MaxNotes];
  logic signed [15:0] nx_q [MaxNotes][3];

  logic [7:0]  lc_q [NumCh];
  logic [15:0] oo_q [NumCh];
  logic [13:0] lx_q [NumCh];
  logic [6:0]  ly_q [NumCh];
  logic [7:0]  lz_q [NumCh];
  logic [15:0] oc_q;

  ph_e ph_q;
  in_t it_q;
  logic [IW:0] i_q;
  logic [IW-1:0] idx_q;
  logic found_q, free_q;
  logic [IW-1:0] fidx_q, freeidx_q;
  logic [3:0] c_q, ch_q, share_q;
  logic [7:0] shcode_q;
  logic [24:0] best_q;
  logic [CW-1:0] cnt_q [NumCh];
  logic [CW-1:0] n_q;
  logic signed [21:0] sum_q [3];
  logic [1:0] m_q;
  logic signed [21:0] rem_q;
  logic [21:0] quo_q;
  logic [4:0] bit_q;
  logic neg_q;
  logic signed [15:0] av_q [3];
  logic [2:0] ecnt_q;
  logic [2:0] emit_n_q;
  logic msg_q;
  out_t out_q;

  assign sts_o.busy = (ph_q != PIdle);
  assign sts_o.has_msg = msg_q;
  assign out_o = out_q;

  logic [IW-1:0] ii;
  assign ii = i_q[IW-1:0];
  logic scan_end;
  assign scan_end = (i_q == (IW+1)'(MaxNotes - 1));

  function automatic logic signed [15:0] asr16(logic signed [15:0] v, logic [1:0] d);
    case (d)
      2'd0: return v >>> 2;
      2'd1: return v >>> 9;
      default: return v >>> 8;
    endcase
  endfunction

  // message for ecnt: averaged send order x, y, z
  function automatic out_t mk_val(logic [1:0] d, logic [3:0] ch, logic signed [15:0] v);
    out_t o;
    logic signed [15:0] r, u;
    r = asr16(v, d);
    o.out_channel = ch;
    o.last = 1'b0;
    case (d)
      2'd0: begin
        u = r + 16'sd8192;
        o.msg_kind = MkBend; o.data_one = u[6:0]; o.data_two = u[13:7];
      end
      2'd1: begin
        u = r + 16'sd64;
        o.msg_kind = MkCc; o.data_one = 7'd74; o.data_two = u[6:0];
      end
      default: begin
        o.msg_kind = MkChPress; o.data_one = r[6:0]; o.data_two = 7'd0;
      end
    endcase
    return o;
  endfunction

  function automatic logic signed [15:0] red(logic [1:0] d, logic signed [15:0] v);
    return asr16(v, d);
  endfunction

  logic signed [15:0] red_x, red_y, red_z;
  assign red_x = red(2'd0, av_q[0]);
  assign red_y = red(2'd1, av_q[1]);
  assign red_z = red(2'd2, av_q[2]);

  logic [3:0] cc;
  assign cc = c_q;
  logic [15:0] tdiff;
  assign tdiff = oc_q - oo_q[cc];
  logic [24:0] gval;
  assign gval = {9'd256 - 9'(cnt_q[cc]), tdiff};

  // restoring divider step on magnitudes
  logic [21:0] absd;
  logic [22:0] trial;
  assign absd = sum_q[m_q][21] ? 22'(-sum_q[m_q]) : 22'(sum_q[m_q]);
  assign trial = {rem_q[21:0], quo_q[21]} - 23'(n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PIdle; nv_q <= '0; msg_q <= 1'b0; oc_q <= 16'd1;
      for (int k = 0; k < NumCh; k++) begin
        lc_q[k] <= 8'd255; oo_q[k] <= '0; lx_q[k] <= '0; ly_q[k] <= '0; lz_q[k] <= '0;
      end
    end else begin
      if (cmd_i.pop) msg_q <= 1'b0;
      case (ph_q)
        PIdle: if (cmd_i.start) begin
          it_q <= in_i; i_q <= '0; found_q <= 1'b0; free_q <= 1'b0;
          ph_q <= (in_i.opcode == OpAllOff) ? PAllOff : PFind;
          c_q <= zone_q ? lm : 4'd0;
        end
        PFind: begin
          if (nv_q[ii] && nn_q[ii] == it_q.note_code && !found_q) begin
            found_q <= 1'b1; fidx_q <= ii;
          end
          if (!nv_q[ii] && !free_q) begin free_q <= 1'b1; freeidx_q <= ii; end
          i_q <= i_q + 1'b1;
          if (scan_end) begin
            logic fnd;
            logic [IW-1:0] fi;
            fnd = found_q || (nv_q[ii] && nn_q[ii] == it_q.note_code);
            fi = found_q ? fidx_q : ii;
            i_q <= '0;
            case (it_q.opcode)
              OpNoteOn: begin
                if (!fnd && !free_q && nv_q[ii]) ph_q <= PDone;
                else begin
                  idx_q <= fnd ? fi : (free_q ? freeidx_q : ii);
                  nv_q[fnd ? fi : (free_q ? freeidx_q : ii)] <= 1'b1;
                  nn_q[fnd ? fi : (free_q ? freeidx_q : ii)] <= it_q.note_code;
                  ni_q[fnd ? fi : (free_q ? freeidx_q : ii)] <= it_q.input_channel;
                  nm_q[fnd ? fi : (free_q ? freeidx_q : ii)] <= NoCh;
                  nx_q[fnd ? fi : (free_q ? freeidx_q : ii)][0] <= it_q.start_x;
                  nx_q[fnd ? fi : (free_q ? freeidx_q : ii)][1] <= it_q.start_y;
                  nx_q[fnd ? fi : (free_q ? freeidx_q : ii)][2] <= it_q.start_z;
                  if (!mpe_q) begin
                    out_q <= '{MkNoteOn, base_q, it_q.note_code, it_q.velocity, 1'b1};
                    msg_q <= 1'b1; ph_q <= PDone;
                  end else begin
                    for (int k = 0; k < NumCh; k++) cnt_q[k] <= '0;
                    share_q <= NoCh; shcode_q <= '0; ph_q <= PCount;
                  end
                end
              end
              OpNoteOff: begin
                if (fnd) nv_q[fi] <= 1'b0;
                if (!mpe_q) begin
                  out_q <= '{MkNoteOff, base_q, it_q.note_code, it_q.velocity, 1'b1};
                  msg_q <= 1'b1; ph_q <= PDone;
                end else if (it_q.member_channel == 4'd15) ph_q <= PDone;
                else begin
                  lc_q[it_q.member_channel] <= {1'b0, it_q.note_code};
                  oo_q[it_q.member_channel] <= oc_q;
                  oc_q <= oc_q + 16'd1;
                  ch_q <= it_q.member_channel;
                  n_q <= '0; sum_q[0] <= '0; sum_q[1] <= '0; sum_q[2] <= '0;
                  ph_q <= POffAvg;
                end
              end
              default: begin
                if (it_q.expr_dimension == 2'd3) ph_q <= PDone;
                else begin
                  if (fnd) nx_q[fi][it_q.expr_dimension] <= it_q.expr_value[31:16];
                  if (!mpe_q) begin
                    if (it_q.expr_dimension == 2'd2) begin
                      out_q <= '{MkPoly, base_q, it_q.expr_value[30:24], it_q.note_code, 1'b1};
                      msg_q <= 1'b1;
                    end
                    ph_q <= PDone;
                  end else if (!fnd || nm_q[fi] == NoCh || nm_q[fi] == 4'd15) ph_q <= PDone;
                  else begin
                    ch_q <= nm_q[fi]; m_q <= it_q.expr_dimension;
                    n_q <= '0; sum_q[it_q.expr_dimension] <= '0; ph_q <= PExSum;
                  end
                end
              end
            endcase
          end
        end
        PCount: begin
          if (nv_q[ii] && nm_q[ii] != NoCh && nm_q[ii] != 4'd15) begin
            cnt_q[nm_q[ii]] <= cnt_q[nm_q[ii]] + 1'b1;
            if (ni_q[ii] == it_q.input_channel && {1'b0, nn_q[ii]} >= shcode_q
                && (share_q == NoCh || {1'b0, nn_q[ii]} > shcode_q)) begin
              share_q <= nm_q[ii]; shcode_q <= {1'b0, nn_q[ii]};
            end
          end
          i_q <= i_q + 1'b1;
          if (scan_end) begin c_q <= lo_c; ch_q <= lo_c; best_q <= '0; ph_q <= PChoose; end
        end
        PChoose: begin
          if (c_q > hi_c) begin
            if (cnt_q[ch_q] != '0 && share_q != NoCh) ch_q <= share_q;
            ph_q <= PAvgLd;
          end else if (lc_q[cc] == {1'b0, it_q.note_code}) begin
            ch_q <= cc; c_q <= 4'd15;
          end else begin
            if (gval > best_q) begin best_q <= gval; ch_q <= cc; end
            c_q <= c_q + 4'd1;
          end
        end
        PAvgLd: begin
          nm_q[idx_q] <= ch_q;
          av_q[0] <= nx_q[idx_q][0]; av_q[1] <= nx_q[idx_q][1]; av_q[2] <= nx_q[idx_q][2];
          if (cnt_q[ch_q] != '0) begin
            n_q <= '0; sum_q[0] <= '0; sum_q[1] <= '0; sum_q[2] <= '0; i_q <= '0;
            ph_q <= POffAvg;
          end else begin ecnt_q <= '0; emit_n_q <= 3'd4; ph_q <= PEmit; end
        end
        POffAvg: begin
          // sum values of notes on ch_q, unassigned notes never count
          if (nv_q[ii] && nm_q[ii] == ch_q && nm_q[ii] != NoCh) begin
            n_q <= n_q + 1'b1;
            for (int k = 0; k < 3; k++) sum_q[k] <= sum_q[k] + 22'(nx_q[ii][k]);
          end
          i_q <= i_q + 1'b1;
          if (scan_end) begin
            logic hit;
            hit = nv_q[ii] && nm_q[ii] == ch_q && nm_q[ii] != NoCh;
            i_q <= '0;
            // note-off word goes out once it is known whether averages follow
            if (it_q.opcode == OpNoteOff) begin
              out_q <= '{MkNoteOff, ch_q, it_q.note_code, it_q.velocity,
                         n_q == '0 && !hit};
              msg_q <= 1'b1;
            end
            if (n_q == '0 && !hit) ph_q <= PDone;
            else begin
              m_q <= 2'd0; bit_q <= 5'd0; ph_q <= PDiv;
              quo_q <= '0; rem_q <= '0;
            end
          end
        end
        PDiv: begin
          // 22 bit restoring divide per dimension
          if (bit_q == 5'd0) begin
            quo_q <= absd; rem_q <= '0; neg_q <= sum_q[m_q][21]; bit_q <= 5'd1;
          end else begin
            if (!trial[22]) begin
              rem_q <= trial[21:0]; quo_q <= {quo_q[20:0], 1'b1};
            end else begin
              rem_q <= {rem_q[20:0], quo_q[21]}; quo_q <= {quo_q[20:0], 1'b0};
            end
            bit_q <= bit_q + 5'd1;
            if (bit_q == 5'd22) begin
              logic [21:0] q;
              q = !trial[22] ? {quo_q[20:0], 1'b1} : {quo_q[20:0], 1'b0};
              av_q[m_q] <= neg_q ? -q[15:0] : q[15:0];
              bit_q <= 5'd0;
              if (m_q == 2'd2) begin
                ecnt_q <= '0;
                emit_n_q <= (it_q.opcode == OpNoteOn) ? 3'd4 : 3'd3;
                ph_q <= PEmit;
              end else m_q <= m_q + 2'd1;
            end
          end
        end
        PEmit: if (!msg_q || cmd_i.pop) begin
          if (ecnt_q < 3'd3) begin
            out_q <= mk_val(ecnt_q[1:0], ch_q, av_q[ecnt_q[1:0]]);
            out_q.last <= (ecnt_q == emit_n_q - 3'd1);
            case (ecnt_q[1:0])
              2'd0: lx_q[ch_q] <= red_x[13:0];
              2'd1: ly_q[ch_q] <= red_y[6:0];
              default: lz_q[ch_q] <= red_z[7:0];
            endcase
          end else begin
            out_q <= '{MkNoteOn, ch_q, it_q.note_code, it_q.velocity, 1'b1};
          end
          msg_q <= 1'b1;
          ecnt_q <= ecnt_q + 3'd1;
          if (ecnt_q == emit_n_q - 3'd1) ph_q <= PDone;
        end
        PExSum: begin
          if (nv_q[ii] && nm_q[ii] == ch_q) begin
            n_q <= n_q + 1'b1;
            sum_q[m_q] <= sum_q[m_q] + 22'(nx_q[ii][m_q]);
          end
          i_q <= i_q + 1'b1;
          if (scan_end) begin
            logic hit;
            hit = nv_q[ii] && nm_q[ii] == ch_q;
            i_q <= '0;
            if (n_q + CW'(hit) > CW'(1)) begin
              n_q <= n_q + CW'(hit);
              if (hit) sum_q[m_q] <= sum_q[m_q] + 22'(nx_q[ii][m_q]);
              bit_q <= '0; ph_q <= PExDiv;
            end else begin
              av_q[m_q] <= it_q.expr_value[31:16]; ph_q <= PExSend;
            end
          end
        end
        PExDiv: begin
          if (bit_q == 5'd0) begin
            quo_q <= absd; rem_q <= '0; neg_q <= sum_q[m_q][21]; bit_q <= 5'd1;
          end else begin
            if (!trial[22]) begin
              rem_q <= trial[21:0]; quo_q <= {quo_q[20:0], 1'b1};
            end else begin
              rem_q <= {rem_q[20:0], quo_q[21]}; quo_q <= {quo_q[20:0], 1'b0};
            end
            bit_q <= bit_q + 5'd1;
            if (bit_q == 5'd22) begin
              logic [21:0] q;
              logic signed [15:0] a, r;
              logic same;
              q = !trial[22] ? {quo_q[20:0], 1'b1} : {quo_q[20:0], 1'b0};
              a = neg_q ? -q[15:0] : q[15:0];
              r = red(m_q, a);
              case (m_q)
                2'd0: same = (r[13:0] == lx_q[ch_q]);
                2'd1: same = (r[6:0] == ly_q[ch_q]);
                default: same = (r[7:0] == lz_q[ch_q]);
              endcase
              av_q[m_q] <= a;
              ph_q <= same ? PDone : PExSend;
            end
          end
        end
        PExSend: if (!msg_q) begin
          out_q <= mk_val(m_q, ch_q, av_q[m_q]);
          out_q.last <= 1'b1;
          case (m_q)
            2'd0: lx_q[ch_q] <= red_x[13:0];
            2'd1: ly_q[ch_q] <= red_y[6:0];
            default: lz_q[ch_q] <= red_z[7:0];
          endcase
          msg_q <= 1'b1; ph_q <= PDone;
        end
        PAllOff: if (!msg_q || cmd_i.pop) begin
          nv_q <= '0;
          if (!mpe_q) begin
            out_q <= '{MkAllOff, base_q, 7'd0, 7'd0, 1'b1};
            msg_q <= 1'b1; ph_q <= PDone;
          end else begin
            out_q <= '{MkAllOff, c_q, 7'd0, 7'd0, c_q == (zone_q ? 4'd15 : hm)};
            msg_q <= 1'b1;
            if (c_q == (zone_q ? 4'd15 : hm)) ph_q <= PDone;
            else c_q <= c_q + 4'd1;
          end
        end
        PDone: if (!msg_q || cmd_i.pop) ph_q <= PIdle;
        default: ph_q <= PIdle;
      endcase
    end
  end

endmodule

// File: src/mpe_member_channel_allocator.sv
// per-event processing time is set by the note table scans, the channel choice and the
// 22-step divider for averages, and by the output handshake of each message word
// one event at a time: the next event is accepted only after its last word has been taken
// reset: asynchronous active low, note table invalid, channel history cleared
module mpe_member_channel_allocator import mpe_pkg::*; #(
  parameter int unsigned MAX_NOTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o
);

  cmd_t cmd;
  sts_t sts;

  mpe_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  mpe_dp #(.MaxNotes(MAX_NOTES)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o)
  );

endmodule

// File: src/mpe_checker.sv
module mpe_checker import mpe_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready during output");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.msg_kind != 3'd7)
    else $error("bad message kind");

endmodule

bind mpe_member_channel_allocator mpe_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
